// ----- rtl/bsc_pkg.sv -----
// Package: shared types, constants and command codes for the barometric compensation block.
package bsc_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned CfgWidth  = 64;
    localparam int unsigned CfgIdxW   = 2;

    localparam logic [CfgIdxW-1:0] RegCalA = 2'd0;
    localparam logic [CfgIdxW-1:0] RegCalB = 2'd1;
    localparam logic [CfgIdxW-1:0] RegCalC = 2'd2;
    localparam logic [CfgIdxW-1:0] RegOss  = 2'd3;

    localparam logic [31:0] B6Offset   = 32'd4000;
    localparam logic [31:0] PolyA      = 32'd3038;
    localparam logic [31:0] PolyB      = 32'hFFFF_E343; // -7357
    localparam logic [31:0] PolyC      = 32'd3791;
    localparam logic [31:0] ScaleConst = 32'd50000;
    localparam logic [31:0] SignBit    = 32'h8000_0000;
    localparam logic [31:0] HalfRange  = 32'd32768;

    typedef struct packed {
        logic        req_type;
        logic [23:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] value;
        logic               divide_error;
    } out_item_t;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_T_X1,      // r0 = asr((ut-ac6)*ac5, 15)
        OP_T_DEN,     // r1 = r0 + md ; zero flag
        OP_T_DIVST,   // start mc<<11 / r1 signed
        OP_T_FIN,     // temp_term = r0 + q ; result
        OP_P_B6,      // r0 = b6, r5 = up
        OP_P_SQ,      // r1 = asr(b6*b6,12)
        OP_P_X1,      // r2 = asr(b2*sq,11)
        OP_P_X2,      // r2 += asr(ac2*b6,11)
        OP_P_B3,      // r3 = b3
        OP_P_X1B,     // r2 = asr(ac3*b6,13)
        OP_P_X2B,     // r2 = asr(r2 + asr(b1*sq,16) + 2, 2)
        OP_P_B4,      // r4 = b4 ; zero flag
        OP_P_B7,      // r2 = b7
        OP_P_DIVST,   // start unsigned divide
        OP_P_PQ,      // r0 = p from quotient
        OP_P_SQP,     // r1 = (p>>8)^2
        OP_P_Y1,      // r1 = asr(r1*3038,16)
        OP_P_Y2,      // r2 = asr(-7357*p,16)
        OP_P_FIN,     // result p
        OP_ERR        // zero divisor result
    } dp_op_t;

    typedef struct packed {
        logic div_busy;
        logic zero;
    } dp_status_t;

endpackage

// ----- rtl/baro_sensor_compensation.sv -----
// Top level of the barometric pressure and temperature compensation block.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid / in_ready     | in_item_t (req_type, raw_sample)
//   out     | output    | out_valid / out_ready   | out_item_t (result_kind, value, divide_error)
//   cfg     | input     | cfg_we, cfg_idx         | cfg_data (64 bits)
//
// A temperature item runs through the temperature micro-operations to its result beat, a
// pressure item through the longer pressure sequence; both wait on the 32-step shared
// divider. A zero divisor skips the divide for the error result. One item is in flight at a
// time; the next beat is taken once the result beat has been accepted. Reset clears the
// calibration registers, sets oversampling to 3 and clears the kept temperature term.
module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [CfgWidth-1:0] cfg_data
);

    dp_op_t     op;
    dp_status_t status;
    logic       load;

    bsc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_type   (in_data.req_type),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .load      (load),
        .op        (op),
        .status    (status)
    );

    bsc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .load     (load),
        .item     (in_data),
        .op       (op),
        .status   (status),
        .result   (out_data)
    );

endmodule

// ----- rtl/bsc_divider.sv -----
// Iterative 32-bit restoring divider, one quotient bit per cycle, optional signed mode.
module bsc_divider
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        is_signed,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    // One shift-subtract step per cycle on magnitudes.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = (is_signed && dividend[31]) ? -dividend : dividend;
            dsr_next  = (is_signed && divisor[31]) ? -divisor : divisor;
            neg_next  = is_signed && (dividend[31] ^ divisor[31]);
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -quo_reg : quo_reg;

endmodule

// ----- rtl/bsc_datapath.sv -----
// Datapath: calibration registers, working registers, shared multiplier and divider.
module bsc_datapath
    import bsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CfgIdxW-1:0] cfg_idx,
    input  logic [CfgWidth-1:0] cfg_data,
    input  logic             load,
    input  in_item_t         item,
    input  dp_op_t           op,
    output dp_status_t       status,
    output out_item_t        result
);

    logic [63:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;
    logic [31:0] temp_term_reg;
    in_item_t    item_reg;
    logic [31:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg, r5_reg;
    logic [31:0] r0_next, r1_next, r2_next, r3_next, r4_next, r5_next;
    logic [31:0] tt_next;
    out_item_t   res_reg, res_next;
    logic        zero_reg, zero_next;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ma, mb, prod;
    logic        div_start, div_signed, div_busy;
    logic [31:0] div_a, div_b, div_q;
    logic [31:0] tmp, x3, pp;

    function automatic logic [31:0] sx16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    assign ac1 = sx16(cal_a_reg[63:48]);
    assign ac2 = sx16(cal_a_reg[47:32]);
    assign ac3 = sx16(cal_a_reg[31:16]);
    assign ac4 = {16'd0, cal_a_reg[15:0]};
    assign ac5 = {16'd0, cal_b_reg[63:48]};
    assign ac6 = {16'd0, cal_b_reg[47:32]};
    assign b1  = sx16(cal_b_reg[31:16]);
    assign b2  = sx16(cal_b_reg[15:0]);
    assign mc  = sx16(cal_c_reg[31:16]);
    assign md  = sx16(cal_c_reg[15:0]);

    // Shared multiplier operand selection: low 32 bits of the product.
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (op)
            OP_T_X1:  begin ma = {16'd0, item_reg.raw_sample[15:0]} - ac6; mb = ac5; end
            OP_P_SQ:  begin ma = r0_reg; mb = r0_reg; end
            OP_P_X1:  begin ma = b2;  mb = r1_reg; end
            OP_P_X2:  begin ma = ac2; mb = r0_reg; end
            OP_P_X1B: begin ma = ac3; mb = r0_reg; end
            OP_P_X2B: begin ma = b1;  mb = r1_reg; end
            OP_P_B4:  begin ma = ac4; mb = r2_reg + HalfRange; end
            OP_P_B7:  begin ma = r5_reg - r3_reg; mb = ScaleConst >> oss_reg; end
            OP_P_SQP: begin ma = asr(r0_reg, 5'd8); mb = asr(r0_reg, 5'd8); end
            OP_P_Y1:  begin ma = r1_reg; mb = PolyA; end
            OP_P_Y2:  begin ma = PolyB; mb = r0_reg; end
            default:  begin ma = '0; mb = '0; end
        endcase
    end

    assign prod = 32'(ma * mb);

    // Divider control.
    always_comb
    begin
        div_start  = 1'b0;
        div_signed = 1'b0;
        div_a      = '0;
        div_b      = r4_reg;
        case (op)
            OP_T_DIVST:
            begin
                div_start  = 1'b1;
                div_signed = 1'b1;
                div_a      = mc << 11;
                div_b      = r1_reg;
            end
            OP_P_DIVST:
            begin
                div_start = 1'b1;
                div_a     = r2_reg[31] ? r2_reg : (r2_reg << 1);
                div_b     = r4_reg;
            end
            default: ;
        endcase
    end

    bsc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .is_signed (div_signed),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .quotient  (div_q)
    );

    // Register updates per micro-operation.
    always_comb
    begin
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        r3_next   = r3_reg;
        r4_next   = r4_reg;
        r5_next   = r5_reg;
        tt_next   = temp_term_reg;
        res_next  = res_reg;
        zero_next = zero_reg;
        tmp       = '0;
        x3        = '0;
        pp        = '0;
        case (op)
            OP_T_X1: r0_next = asr(prod, 5'd15);
            OP_T_DEN:
            begin
                r1_next   = r0_reg + md;
                zero_next = (r0_reg + md) == 32'd0;
            end
            OP_T_FIN:
            begin
                tmp = r0_reg + div_q;
                tt_next = tmp;
                res_next.result_kind  = 1'b0;
                res_next.value        = asr(tmp + 32'd8, 5'd4);
                res_next.divide_error = 1'b0;
            end
            OP_P_B6:
            begin
                r0_next = temp_term_reg - B6Offset;
                r5_next = {8'd0, item_reg.raw_sample} >> (4'd8 - {2'd0, oss_reg});
            end
            OP_P_SQ:  r1_next = asr(prod, 5'd12);
            OP_P_X1:  r2_next = asr(prod, 5'd11);
            OP_P_X2:  r2_next = r2_reg + asr(prod, 5'd11);
            OP_P_B3:
            begin
                x3 = ((ac1 << 2) + r2_reg) << oss_reg;
                r3_next = asr(x3 + 32'd2, 5'd2);
            end
            OP_P_X1B: r2_next = asr(prod, 5'd13);
            OP_P_X2B: r2_next = asr(r2_reg + asr(prod, 5'd16) + 32'd2, 5'd2);
            OP_P_B4:
            begin
                r4_next   = prod >> 15;
                zero_next = (prod >> 15) == 32'd0;
            end
            OP_P_B7: r2_next = prod;
            OP_P_PQ: r0_next = r2_reg[31] ? (div_q << 1) : div_q;
            OP_P_SQP: r1_next = prod;
            OP_P_Y1:  r1_next = asr(prod, 5'd16);
            OP_P_Y2:  r2_next = asr(prod, 5'd16);
            OP_P_FIN:
            begin
                pp = r0_reg + asr(r1_reg + r2_reg + PolyC, 5'd4);
                res_next.result_kind  = 1'b1;
                res_next.value        = pp;
                res_next.divide_error = 1'b0;
            end
            OP_ERR:
            begin
                res_next.result_kind  = item_reg.req_type;
                res_next.value        = '0;
                res_next.divide_error = 1'b1;
            end
            default: ;
        endcase
    end

    // Configuration and kept state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg     <= '0;
            cal_b_reg     <= '0;
            cal_c_reg     <= '0;
            oss_reg       <= 2'd3;
            temp_term_reg <= '0;
        end
        else
        begin
            temp_term_reg <= tt_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    RegCalA: cal_a_reg <= cfg_data;
                    RegCalB: cal_b_reg <= cfg_data;
                    RegCalC: cal_c_reg <= cfg_data[31:0];
                    RegOss:  oss_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        r3_reg   <= r3_next;
        r4_reg   <= r4_next;
        r5_reg   <= r5_next;
        res_reg  <= res_next;
        zero_reg <= zero_next;
    end

    assign status.div_busy = div_busy;
    assign status.zero     = zero_reg;
    assign result          = res_reg;

endmodule

// ----- rtl/bsc_controller.sv -----
// Controller: sequences micro-operations and runs the input and output handshakes.
module bsc_controller
    import bsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_type,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       load,
    output dp_op_t     op,
    input  dp_status_t status
);

    typedef enum logic [4:0] {
        S_IDLE, S_T_X1, S_T_DEN, S_T_CHK, S_T_WAIT, S_T_FIN,
        S_P_B6, S_P_SQ, S_P_X1, S_P_X2, S_P_B3, S_P_X1B, S_P_X2B, S_P_B4,
        S_P_B7, S_P_CHK, S_P_WAIT, S_P_PQ, S_P_SQP, S_P_Y1, S_P_Y2, S_P_FIN,
        S_ERR, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   wait_reg, wait_next;

    // Next state and operation decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        wait_next      = 1'b0;
        op             = OP_NONE;
        load           = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    load       = 1'b1;
                    state_next = in_type ? S_P_B6 : S_T_X1;
                end
            end
            S_T_X1:  begin op = OP_T_X1;  state_next = S_T_DEN; end
            S_T_DEN: begin op = OP_T_DEN; state_next = S_T_CHK; end
            S_T_CHK:
            begin
                if (status.zero)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    op = OP_T_DIVST;
                    wait_next  = 1'b1;
                    state_next = S_T_WAIT;
                end
            end
            S_T_WAIT: if (!wait_reg && !status.div_busy) state_next = S_T_FIN;
            S_T_FIN: begin op = OP_T_FIN; state_next = S_OUT; end
            S_P_B6:  begin op = OP_P_B6;  state_next = S_P_SQ; end
            S_P_SQ:  begin op = OP_P_SQ;  state_next = S_P_X1; end
            S_P_X1:  begin op = OP_P_X1;  state_next = S_P_X2; end
            S_P_X2:  begin op = OP_P_X2;  state_next = S_P_B3; end
            S_P_B3:  begin op = OP_P_B3;  state_next = S_P_X1B; end
            S_P_X1B: begin op = OP_P_X1B; state_next = S_P_X2B; end
            S_P_X2B: begin op = OP_P_X2B; state_next = S_P_B4; end
            S_P_B4:  begin op = OP_P_B4;  state_next = S_P_B7; end
            S_P_B7:  begin op = OP_P_B7;  state_next = S_P_CHK; end
            S_P_CHK:
            begin
                if (status.zero)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    op = OP_P_DIVST;
                    wait_next  = 1'b1;
                    state_next = S_P_WAIT;
                end
            end
            S_P_WAIT: if (!wait_reg && !status.div_busy) state_next = S_P_PQ;
            S_P_PQ:  begin op = OP_P_PQ;  state_next = S_P_SQP; end
            S_P_SQP: begin op = OP_P_SQP; state_next = S_P_Y1; end
            S_P_Y1:  begin op = OP_P_Y1;  state_next = S_P_Y2; end
            S_P_Y2:  begin op = OP_P_Y2;  state_next = S_P_FIN; end
            S_P_FIN: begin op = OP_P_FIN; state_next = S_OUT; end
            S_ERR:   begin op = OP_ERR;   state_next = S_OUT; end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // A new item is taken only once the previous result has left the register.
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wait_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wait_reg      <= wait_next;
        end
    end

endmodule
